// File: src/sed_pkg.sv
package sed_pkg;

  // Escape decoder mode, one-hot
  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_ESCAPE = 4'b0010,
    MODE_HEX    = 4'b0100,
    MODE_OCTAL  = 4'b1000
  } mode_t;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_ZERO      = 8'h30;

  localparam logic [1:0] HEX_DIGITS = 2'd2;
  localparam logic [1:0] OCT_DIGITS = 2'd3;

  // Queue between the decoder and the result stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Results caused by one character: one, or two when two is set
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic       end0;
    logic [7:0] byte1;
    logic       end1;
  } entry_t;

  // Hex digit value; valid bit on top
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Control code for a simple escape letter; the letter itself otherwise
  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h61:   r = 8'd7;
      8'h62:   r = 8'd8;
      8'h66:   r = 8'd12;
      8'h6E:   r = 8'd10;
      8'h72:   r = 8'd13;
      8'h74:   r = 8'd9;
      8'h76:   r = 8'd11;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

// File: src/string_escape_decoder_top.sv
// String escape decoder. Feed the raw characters of a quoted string body, one
// per push; decoded bytes come out in order, one beat per pop. A backslash
// starts an escape (a b f n r t v give control codes, x takes up to two hex
// digits, 0 takes up to three octal digits wrapping to 8 bits, anything else
// stands for itself). An unescaped quote or a zero byte ends the literal and
// yields one beat with end_flag set and byte_out zero. Each character yields
// zero, one or two beats; last marks the final beat of a character. A new
// character is taken every cycle while the 4-entry internal queue has room;
// the output stage drains one beat per cycle while pop is held; the two beats
// of a character pass the output one after the other. A pushed character's
// first beat is written to the queue, then loaded into the output register.
module string_escape_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] byte_out,
  output logic       end_flag,
  output logic       last
);
  import sed_pkg::*;

  logic   accept;
  logic   q_wr, q_rd, q_valid, q_full;
  entry_t q_wdata, q_rdata;
  logic   out_valid;
  logic   phase;

  // Take a character whenever the queue has room
  assign accept = push && !q_full;
  assign full   = q_full;
  assign empty  = !out_valid;

  // Decode: hold escape state, classify each character into result beats
  sed_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .char_in (char_in),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  // Decouple decode from result delivery
  sed_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_wr),
    .wdata     (q_wdata),
    .rd        (q_rd),
    .rdata     (q_rdata),
    .not_empty (q_valid),
    .full      (q_full)
  );

  // Serialize one or two beats per entry into the output register
  sed_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_rd      (q_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .phase     (phase),
    .byte_out  (byte_out),
    .end_flag  (end_flag),
    .last      (last)
  );

  // Never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_wr)
    else $error("write into full queue");

  // End beats carry a zero byte
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_flag) |-> (byte_out == 8'd0))
    else $error("end beat with nonzero byte");

  // Second beat pending means its entry is still queued
  a_phase_held: assert property (@(posedge clk) disable iff (rst)
    phase |-> q_valid)
    else $error("second beat pending with empty queue");

  // The first beat of a two-beat entry is never marked last
  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && phase) |-> !last)
    else $error("first of two beats marked last");

  // Reset leaves no beat on the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("output not empty after reset");

endmodule

// File: src/sed_front.sv
module sed_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    char_in,
  output logic          q_wr,
  output sed_pkg::entry_t q_wdata
);
  import sed_pkg::*;

  mode_t      mode, mode_next;
  logic [1:0] digits_left, digits_left_next;
  logic [7:0] escape_accum, escape_accum_next;
  logic [1:0] n_res;
  logic [4:0] hv;
  logic       dig_ok;
  logic [3:0] dig;
  logic [7:0] acc_new;
  logic [1:0] dl_new;
  logic       is_end;

  always_comb begin
    mode_next         = mode;
    digits_left_next  = digits_left;
    escape_accum_next = escape_accum;
    n_res             = 2'd0;
    q_wdata           = '0;
    hv                = hex_value(char_in);
    is_end            = (char_in == CH_NUL) || (char_in == CH_QUOTE);
    dig_ok            = 1'b0;
    dig               = 4'd0;
    acc_new           = 8'd0;
    dl_new            = digits_left - 2'd1;
    if (mode == MODE_HEX) begin
      dig_ok  = hv[4];
      dig     = hv[3:0];
      acc_new = {escape_accum[3:0], 4'd0} + {4'd0, dig};
    end else begin
      dig_ok  = (char_in >= CH_ZERO) && (char_in <= 8'h37);
      dig     = {1'b0, char_in[2:0]};
      acc_new = {escape_accum[4:0], 3'd0} + {4'd0, dig};
    end
    case (mode)
      MODE_NORMAL: begin
        if (is_end) begin
          n_res          = 2'd1;
          q_wdata.end0   = 1'b1;
          mode_next         = MODE_NORMAL;
          digits_left_next  = 2'd0;
          escape_accum_next = 8'd0;
        end else if (char_in == CH_BACKSLASH) begin
          mode_next = MODE_ESCAPE;
        end else begin
          n_res         = 2'd1;
          q_wdata.byte0 = char_in;
        end
      end
      MODE_ESCAPE: begin
        mode_next = MODE_NORMAL;
        if (char_in == CH_NUL) begin
          n_res             = 2'd1;
          q_wdata.end0      = 1'b1;
          digits_left_next  = 2'd0;
          escape_accum_next = 8'd0;
        end else if (char_in == CH_X) begin
          mode_next         = MODE_HEX;
          digits_left_next  = HEX_DIGITS;
          escape_accum_next = 8'd0;
        end else if (char_in == CH_ZERO) begin
          mode_next         = MODE_OCTAL;
          digits_left_next  = OCT_DIGITS;
          escape_accum_next = 8'd0;
        end else begin
          n_res         = 2'd1;
          q_wdata.byte0 = escape_map(char_in);
        end
      end
      MODE_HEX, MODE_OCTAL: begin
        if (dig_ok) begin
          escape_accum_next = acc_new;
          digits_left_next  = dl_new;
          if (dl_new == 2'd0) begin
            n_res             = 2'd1;
            q_wdata.byte0     = acc_new;
            mode_next         = MODE_NORMAL;
            escape_accum_next = 8'd0;
          end
        end else begin
          // flush the pending byte, then treat the character as plain
          n_res             = 2'd1;
          q_wdata.byte0     = escape_accum;
          mode_next         = MODE_NORMAL;
          digits_left_next  = 2'd0;
          escape_accum_next = 8'd0;
          if (is_end) begin
            n_res        = 2'd2;
            q_wdata.end1 = 1'b1;
          end else if (char_in == CH_BACKSLASH) begin
            mode_next = MODE_ESCAPE;
          end else begin
            n_res         = 2'd2;
            q_wdata.byte1 = char_in;
          end
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
      end
    endcase
    q_wdata.two = (n_res == 2'd2);
  end

  assign q_wr = accept && (n_res != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NORMAL;
      digits_left  <= 2'd0;
      escape_accum <= 8'd0;
    end else if (accept) begin
      mode         <= mode_next;
      digits_left  <= digits_left_next;
      escape_accum <= escape_accum_next;
    end
  end

endmodule

// File: src/sed_queue.sv
module sed_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  sed_pkg::entry_t wdata,
  input  logic            rd,
  output sed_pkg::entry_t rdata,
  output logic            not_empty,
  output logic            full
);
  import sed_pkg::*;

  entry_t           mem [QDEPTH];
  logic [QAW-1:0]   wp, rp;
  logic [QCW-1:0]   count;

  assign full      = (count == QCW'(QDEPTH));
  assign not_empty = (count != '0);
  assign rdata     = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wp <= wp + QAW'(1);
      end
      if (rd) begin
        rp <= rp + QAW'(1);
      end
      count <= count + QCW'(wr) - QCW'(rd);
    end
  end

endmodule

// File: src/sed_back.sv
module sed_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  sed_pkg::entry_t q_rdata,
  output logic            q_rd,
  input  logic            pop,
  output logic            out_valid,
  output logic            phase,
  output logic [7:0]      byte_out,
  output logic            end_flag,
  output logic            last
);
  import sed_pkg::*;

  logic load;

  // Load a new beat when the output register is free or being drained
  assign load = q_valid && (!out_valid || pop);
  assign q_rd = load && (phase || !q_rdata.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= phase ? 1'b0 : q_rdata.two;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_out <= phase ? q_rdata.byte1 : q_rdata.byte0;
      end_flag <= phase ? q_rdata.end1 : q_rdata.end0;
      last     <= phase || !q_rdata.two;
    end
  end

endmodule

// File: sim/string_escape_decoder_top_tb.sv
`timescale 1ns / 100ps

module string_escape_decoder_top_tb;
  import sed_pkg::*;

  // Run length and pacing
  localparam int    RANDOM_CHARS = 1250;
  localparam int    FILL_CHARS   = 100;   // sent once the sink is told to hold off
  localparam int    LONG_HOLD    = 300;   // cycles the sink refuses beats
  localparam int    TAIL_CYCLES  = 8;     // quiet time after the last beat
  localparam int    PRED         = -1;    // row count: use the predictor
  localparam int    NUM_ROWS     = 30;
  localparam time   TIMEOUT      = 8ms;

  // One decoded beat as it leaves the block
  typedef struct packed {
    logic [7:0] data;
    logic       ended;
    logic       is_last;
  } beat_t;

  // One directed stimulus row: the character and, where it is obvious, the
  // beats it must produce (count, then data/end of up to two beats)
  typedef struct packed {
    logic [7:0] ch;
    int         n;
    logic [7:0] d0;
    logic       e0;
    logic [7:0] d1;
    logic       e1;
  } char_row_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] char_in;
  logic       empty;
  logic       pop;
  logic [7:0] byte_out;
  logic       end_flag;
  logic       last;

  string_escape_decoder_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .char_in  (char_in),
    .empty    (empty),
    .pop      (pop),
    .byte_out (byte_out),
    .end_flag (end_flag),
    .last     (last)
  );

  // Decoder state mirrored by the predictor
  mode_t      dec_mode   = MODE_NORMAL;
  logic [1:0] digits_rem = 2'd0;
  logic [7:0] accum      = 8'd0;

  beat_t      pending_bytes[$];   // decoded beats still owed by the block
  int         mismatches = 0;
  int         chars_sent = 0;     // random characters accepted so far

  // Idle knobs shared between the feeder and the sink
  int         tx_gap_pct   = 0;
  int         rx_stall_pct = 0;
  bit         hold_req     = 1'b0;

  // Directed characters. Backslash rows and the x or 0 opening a numeric escape
  // produce nothing; the first two octal digits go through the predictor.
  char_row_t script [NUM_ROWS] = '{
    '{"A",          1,    "A",   1'b0, 8'h00, 1'b0},
    '{8'hFF,        1,    8'hFF, 1'b0, 8'h00, 1'b0},
    '{CH_QUOTE,     1,    8'h00, 1'b1, 8'h00, 1'b0},  // closing quote
    '{CH_NUL,       1,    8'h00, 1'b1, 8'h00, 1'b0},  // end of text
    '{CH_BACKSLASH, 0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{"a",          1,    8'd7,  1'b0, 8'h00, 1'b0},
    '{CH_BACKSLASH, 0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{"b",          1,    8'd8,  1'b0, 8'h00, 1'b0},
    '{CH_BACKSLASH, 0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{"f",          1,    8'd12, 1'b0, 8'h00, 1'b0},
    '{CH_BACKSLASH, 0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{"n",          1,    8'd10, 1'b0, 8'h00, 1'b0},
    '{CH_BACKSLASH, 0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{"r",          1,    8'd13, 1'b0, 8'h00, 1'b0},
    '{CH_BACKSLASH, 0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{"t",          1,    8'd9,  1'b0, 8'h00, 1'b0},
    '{CH_BACKSLASH, 0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{"v",          1,    8'd11, 1'b0, 8'h00, 1'b0},
    // hex escape with no digits cut short by a quote: flush zero, then end
    '{CH_BACKSLASH, 0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{CH_X,         0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{CH_QUOTE,     2,    8'h00, 1'b0, 8'h00, 1'b1},
    // octal 777 wraps to ff
    '{CH_BACKSLASH, 0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{CH_ZERO,      0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{"7",          PRED, 8'h00, 1'b0, 8'h00, 1'b0},
    '{"7",          PRED, 8'h00, 1'b0, 8'h00, 1'b0},
    '{"7",          1,    8'hFF, 1'b0, 8'h00, 1'b0},
    // zero byte after a backslash ends the literal, escape dropped
    '{CH_BACKSLASH, 0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{CH_NUL,       1,    8'h00, 1'b1, 8'h00, 1'b0},
    // escaped quote is a plain quote
    '{CH_BACKSLASH, 0,    8'h00, 1'b0, 8'h00, 1'b0},
    '{CH_QUOTE,     1,    CH_QUOTE, 1'b0, 8'h00, 1'b0}
  };

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic int oct_digit(input logic [7:0] c);
    if (c >= "0" && c <= "7") return c - "0";
    return -1;
  endfunction

  // Byte for a single-letter escape; anything else stands for itself
  function automatic logic [7:0] ctrl_code(input logic [7:0] c);
    case (c)
      "a":     return 8'd7;
      "b":     return 8'd8;
      "f":     return 8'd12;
      "n":     return 8'd10;
      "r":     return 8'd13;
      "t":     return 8'd9;
      "v":     return 8'd11;
      default: return c;
    endcase
  endfunction

  // Advance the decoder by one character; queue its beats when asked
  task automatic decode_char(input logic [7:0] c, input bit enqueue);
    beat_t out [2];
    int    n;
    int    digit;
    bit    plain;
    n     = 0;
    plain = 1'b0;
    case (dec_mode)
      MODE_HEX, MODE_OCTAL: begin
        digit = (dec_mode == MODE_HEX) ? hex_digit(c) : oct_digit(c);
        if (digit < 0) begin
          // non-digit: flush what was gathered, then treat c as plain text
          out[n] = '{accum, 1'b0, 1'b0};
          n++;
          dec_mode   = MODE_NORMAL;
          digits_rem = 2'd0;
          accum      = 8'd0;
          plain      = 1'b1;
        end else begin
          accum = (dec_mode == MODE_HEX) ? {accum[3:0], 4'(digit)}
                                         : {accum[4:0], 3'(digit)};
          digits_rem = digits_rem - 2'd1;
          if (digits_rem == 2'd0) begin
            out[n] = '{accum, 1'b0, 1'b0};
            n++;
            dec_mode = MODE_NORMAL;
            accum    = 8'd0;
          end
        end
      end
      MODE_ESCAPE: begin
        if (c == CH_NUL) begin
          out[n] = '{8'h00, 1'b1, 1'b0};
          n++;
          dec_mode = MODE_NORMAL;
        end else if (c == CH_X) begin
          dec_mode   = MODE_HEX;
          digits_rem = HEX_DIGITS;
          accum      = 8'd0;
        end else if (c == CH_ZERO) begin
          dec_mode   = MODE_OCTAL;
          digits_rem = OCT_DIGITS;
          accum      = 8'd0;
        end else begin
          out[n] = '{ctrl_code(c), 1'b0, 1'b0};
          n++;
          dec_mode = MODE_NORMAL;
        end
      end
      default: plain = 1'b1;
    endcase
    if (plain) begin
      if (c == CH_NUL || c == CH_QUOTE) begin
        out[n] = '{8'h00, 1'b1, 1'b0};
        n++;
        dec_mode   = MODE_NORMAL;
        digits_rem = 2'd0;
        accum      = 8'd0;
      end else if (c == CH_BACKSLASH) begin
        dec_mode = MODE_ESCAPE;
      end else begin
        out[n] = '{c, 1'b0, 1'b0};
        n++;
      end
    end
    if (enqueue) begin
      for (int i = 0; i < n; i++) begin
        out[i].is_last = (i == n - 1);
        pending_bytes.push_back(out[i]);
      end
    end
  endtask

  // Pick an idle stretch for the feeder: mostly none or short, a few long
  function automatic int pick_gap();
    if (tx_gap_pct == 0 || $urandom_range(0, 99) >= tx_gap_pct) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Offer one character starting at a falling edge, hold it until taken,
  // predict its beats and return at the next falling edge.
  task automatic send_char(input char_row_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    char_in <= row.ch;
    do @(posedge clk); while (full);
    if (row.n == PRED) begin
      decode_char(row.ch, 1'b1);
    end else begin
      // state still advances; the table row supplies the beats
      decode_char(row.ch, 1'b0);
      if (row.n >= 1) pending_bytes.push_back('{row.d0, row.e0, row.n == 1});
      if (row.n == 2) pending_bytes.push_back('{row.d1, row.e1, 1'b1});
    end
    @(negedge clk);
  endtask

  task automatic send_random(input logic [7:0] c);
    send_char('{c, PRED, 8'h00, 1'b0, 8'h00, 1'b0});
    chars_sent++;
  endtask

  // One random token: well-formed escapes with random content, plus raw
  // noise, escapes cut short and literal ends.
  task automatic send_token();
    string hex_set;
    string esc_set;
    int    kind;
    int    ndig;
    hex_set = "0123456789abcdefABCDEF";
    esc_set = "abfnrtv";
    kind    = $urandom_range(0, 99);
    if (kind < 10) begin
      send_random(8'($urandom_range(0, 255)));
    end else if (kind < 35) begin
      send_random(8'($urandom_range(8'h20, 8'h7E)));
    end else if (kind < 50) begin
      send_random(CH_BACKSLASH);
      send_random(esc_set[$urandom_range(0, 6)]);
    end else if (kind < 65) begin
      send_random(CH_BACKSLASH);
      send_random(CH_X);
      ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : 2;
      for (int i = 0; i < ndig; i++) send_random(hex_set[$urandom_range(0, 21)]);
    end else if (kind < 80) begin
      send_random(CH_BACKSLASH);
      send_random(CH_ZERO);
      ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 3;
      for (int i = 0; i < ndig; i++) send_random(8'("0" + $urandom_range(0, 7)));
    end else if (kind < 90) begin
      send_random(CH_BACKSLASH);
      send_random(8'($urandom_range(0, 255)));
    end else begin
      send_random($urandom_range(0, 1) ? CH_QUOTE : CH_NUL);
    end
  endtask

  // Hold the feeder until every owed beat has come out
  task automatic wait_drained();
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  // Sink: decide pop at each falling edge. Random stalls, mostly short with
  // the odd long one; a hold request from the feeder forces a long stretch.
  initial begin : sink
    int hold;
    hold = 0;
    pop  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold     = LONG_HOLD;
        hold_req = 1'b0;
      end else if (hold == 0 && rx_stall_pct != 0 &&
                   $urandom_range(0, 99) < rx_stall_pct) begin
        hold = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                            : $urandom_range(1, 3);
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Compare each accepted beat against the oldest owed beat
  always @(posedge clk) begin : check_beat
    beat_t owed;
    if (!rst && pop && !empty) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected beat: byte_out=%02h end_flag=%0b last=%0b",
               byte_out, end_flag, last);
        mismatches++;
      end else begin
        owed = pending_bytes.pop_front();
        if (byte_out !== owed.data) begin
          $error("byte_out: expected %02h, got %02h", owed.data, byte_out);
          mismatches++;
        end
        if (end_flag !== owed.ended) begin
          $error("end_flag: expected %0b, got %0b", owed.ended, end_flag);
          mismatches++;
        end
        if (last !== owed.is_last) begin
          $error("last: expected %0b, got %0b", owed.is_last, last);
          mismatches++;
        end
      end
    end
  end

  // Feeder: reset, directed table, then random phases
  initial begin : feeder
    rst     = 1'b1;
    push    = 1'b0;
    char_in = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows back to back, sink always ready
    for (int i = 0; i < NUM_ROWS; i++) send_char(script[i]);

    // pause the feeder until everything owed has drained
    push <= 1'b0;
    wait_drained();
    @(negedge clk);

    // stream with no idling on either side
    while (chars_sent < 300) send_token();

    // hold the sink off and keep feeding so the block backs up into full
    hold_req = 1'b1;
    while (chars_sent < 300 + FILL_CHARS) send_token();

    // random gaps and stalls on both sides
    tx_gap_pct   = 30;
    rx_stall_pct = 30;
    while (chars_sent < 900) send_token();

    // light feeder, heavy sink
    tx_gap_pct   = 5;
    rx_stall_pct = 60;
    while (chars_sent < RANDOM_CHARS) send_token();

    push <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT);
    $display("Verification failed");
    $finish;
  end

endmodule
